// ===== design/lsp2lpc_pkg.sv =====
// Shared types, widths and constants for the LSP to LPC converter.
// No dependencies; every module of the block imports this package.
package lsp2lpc_pkg;

  localparam int LPC_ORDER  = 10;  // default filter order
  localparam int LSP_W      = 16;  // Q15 input word
  localparam int POLY_W     = 48;  // Q24 polynomial coefficient
  localparam int COEF_W     = 16;  // Q12 output coefficient
  localparam int COEF_IDX_W = 4;
  localparam int PROD_SHIFT = 16;  // product is floor(x*c / 2^16) * 4
  localparam int OUT_PAD_W  = 4;   // zero fill of the output tdata to whole bytes
  localparam int OUT_DATA_W = COEF_W + COEF_IDX_W + OUT_PAD_W;
  localparam int ROUND_W    = POLY_W + 4;

  localparam logic signed [POLY_W-1:0] P_ONE     = POLY_W'(1) << 24;  // 1.0 in Q24
  localparam logic signed [COEF_W-1:0] COEF_LEAD = 16'sd4096;         // 1.0 in Q12
  localparam logic signed [ROUND_W-1:0] SAT_HI   = 52'sd32767;
  localparam logic signed [ROUND_W-1:0] SAT_LO   = -52'sd32768;
  localparam logic signed [ROUND_W-1:0] RND_HALF = 52'sd32768;

  typedef struct packed {
    logic signed [COEF_W-1:0] value;
    logic [COEF_IDX_W-1:0]    index;
    logic                     last;
  } coef_word_t;

  // Q24 sum to Q12: scale by 8, round at bit 15, floor shift by 16, saturate.
  function automatic logic signed [COEF_W-1:0] coef_round(input logic signed [POLY_W-1:0] t);
    logic signed [ROUND_W-1:0] v;
    logic signed [ROUND_W-1:0] sh;
    v  = (ROUND_W'(t) <<< 3) + RND_HALF;
    sh = v >>> 16;
    if (sh > SAT_HI) begin
      coef_round = SAT_HI[COEF_W-1:0];
    end else if (sh < SAT_LO) begin
      coef_round = SAT_LO[COEF_W-1:0];
    end else begin
      coef_round = sh[COEF_W-1:0];
    end
  endfunction

endpackage

// ===== design/lsp2lpc_mul.sv =====
// Shared multiply unit: floor(x*c / 2^16) * 4 for a 16-bit x and a 48-bit c.
// One 16x25 multiplier used twice (low half, then high half). Uses lsp2lpc_pkg.
module lsp2lpc_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [lsp2lpc_pkg::LSP_W-1:0]   x,
  input  logic signed [lsp2lpc_pkg::POLY_W-1:0]  c,
  output logic                                   done,
  output logic signed [lsp2lpc_pkg::POLY_W-1:0]  prod
);
  import lsp2lpc_pkg::*;

  localparam int HALF_W = POLY_W / 2;
  localparam int PART_W = LSP_W + HALF_W + 1;
  localparam int ACC_W  = LSP_W + POLY_W;

  logic                     busy;
  logic                     phase;
  logic signed [LSP_W-1:0]  x_r;
  logic signed [POLY_W-1:0] c_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [HALF_W:0]   mul_b;
  logic signed [PART_W-1:0] part;

  // low half is unsigned, high half carries the sign
  assign mul_b = phase ? {c_r[POLY_W-1], c_r[POLY_W-1:HALF_W]} : {1'b0, c_r[HALF_W-1:0]};
  assign part  = x_r * mul_b;
  assign prod  = {acc[POLY_W-3+PROD_SHIFT:PROD_SHIFT], 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end else if (busy) begin
        if (phase) begin
          busy  <= 1'b0;
          phase <= 1'b0;
          done  <= 1'b1;
        end else begin
          phase <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      c_r <= c;
    end else if (busy) begin
      acc <= phase ? acc + (ACC_W'(part) <<< HALF_W) : ACC_W'(part);
    end
  end

endmodule

// ===== design/lsp2lpc_core.sv =====
// Sequencer of the converter: LSP word store, polynomial memory, build and output passes.
// Drives the shared multiply unit lsp2lpc_mul. Uses lsp2lpc_pkg.
module lsp2lpc_core #(
  parameter int ORDER = lsp2lpc_pkg::LPC_ORDER
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [lsp2lpc_pkg::LSP_W-1:0] in_value,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output lsp2lpc_pkg::coef_word_t              res
);
  import lsp2lpc_pkg::*;

  localparam int HALF   = ORDER / 2;
  localparam int NCOEF  = 2 * HALF + 1;
  localparam int DEPTH  = 2 * (HALF + 1);
  localparam int CNT_W  = $clog2(ORDER);
  localparam int IDX_W  = $clog2(HALF + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int K_W    = $clog2(NCOEF);

  typedef enum logic [3:0] {
    S_LOAD, S_RJ, S_RM, S_RN, S_ADD, S_WB,
    S_OI, S_OA, S_OB, S_OC, S_OD, S_OE, S_OF
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  load_count;
  logic              sel;
  logic [IDX_W-1:0]  step;
  logic [IDX_W-1:0]  j;
  logic [K_W-1:0]    k;

  logic signed [LSP_W-1:0]  pair_store [ORDER];
  logic signed [POLY_W-1:0] poly_mem [DEPTH];
  logic signed [POLY_W-1:0] rdata;
  logic signed [POLY_W-1:0] acc_a;
  logic signed [POLY_W-1:0] acc_b;

  logic                     rd_sel;
  logic [IDX_W-1:0]         rd_idx;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic [IDX_W-1:0]         wr_idx;
  logic [K_W-1:0]           k_mirror;
  logic                     coef_neg;
  logic [IDX_W-1:0]         out_i;
  logic                     mul_start;
  logic                     mul_done;
  logic signed [LSP_W-1:0]  mul_x;
  logic signed [POLY_W-1:0] mul_prod;
  logic                     last_k;

  assign in_ready  = (state == S_LOAD);
  assign res_valid = (state == S_OF);
  assign mul_start = (state == S_RM);
  assign mul_x     = pair_store[CNT_W'({step, sel})];
  assign last_k    = (k == K_W'(NCOEF - 1));

  // coefficient k and NCOEF-k come from the same folded pair
  assign k_mirror = K_W'(NCOEF) - k;
  assign coef_neg = (k > K_W'(HALF));
  assign out_i    = IDX_W'(coef_neg ? k_mirror : k);

  assign wr_idx  = IDX_W'(j + 1'b1);
  assign wr_addr = sel ? ADDR_W'(HALF + 1) + ADDR_W'(wr_idx) : ADDR_W'(wr_idx);
  assign rd_addr = rd_sel ? ADDR_W'(HALF + 1) + ADDR_W'(rd_idx) : ADDR_W'(rd_idx);

  assign res.value = (k == '0) ? COEF_LEAD : coef_round(acc_a);
  assign res.index = COEF_IDX_W'(k);
  assign res.last  = last_k;

  always_comb begin
    rd_sel = sel;
    rd_idx = j;
    unique case (state)
      S_RM: rd_idx = (j == '0) ? '0 : IDX_W'(j - 1'b1);
      S_RN: rd_idx = wr_idx;
      S_OI: begin
        rd_sel = 1'b0;
        rd_idx = out_i;
      end
      S_OA: begin
        rd_sel = 1'b0;
        rd_idx = IDX_W'(out_i - 1'b1);
      end
      S_OB: begin
        rd_sel = 1'b1;
        rd_idx = out_i;
      end
      S_OC: begin
        rd_sel = 1'b1;
        rd_idx = IDX_W'(out_i - 1'b1);
      end
      default: ;
    endcase
  end

  lsp2lpc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .c     (rdata),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Datapath: read data is registered, in the cycle after its address; entry 0 is always 1.0
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pair_store[load_count] <= in_value;
    end
    rdata <= (rd_idx == '0) ? P_ONE : poly_mem[rd_addr];
    case (state)
      S_RN: begin
        if (j == '0) begin
          acc_b <= '0;
        end else if (j == step) begin
          acc_b <= rdata <<< 1;
        end else begin
          acc_b <= rdata;
        end
      end
      // the top term of a step starts from zero
      S_ADD: acc_a <= ((j == step) ? '0 : rdata) + acc_b;
      S_WB: begin
        if (mul_done) begin
          poly_mem[wr_addr] <= acc_a - mul_prod;
        end
      end
      S_OA: acc_a <= rdata;
      S_OB: acc_a <= acc_a + rdata;
      S_OC: acc_b <= rdata;
      S_OD: acc_b <= acc_b - rdata;
      S_OE: acc_a <= coef_neg ? acc_a - acc_b : acc_a + acc_b;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      sel        <= 1'b0;
      step       <= '0;
      j          <= '0;
      k          <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (load_count == CNT_W'(ORDER - 1)) begin
              load_count <= '0;
              sel        <= 1'b0;
              step       <= '0;
              j          <= '0;
              state      <= S_RJ;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_RJ:  state <= S_RM;
        S_RM:  state <= S_RN;
        S_RN:  state <= S_ADD;
        S_ADD: state <= S_WB;
        S_WB: begin
          if (mul_done) begin
            if (j != '0) begin
              j     <= IDX_W'(j - 1'b1);
              state <= S_RJ;
            end else if (step != IDX_W'(HALF - 1)) begin
              step  <= IDX_W'(step + 1'b1);
              j     <= IDX_W'(step + 1'b1);
              state <= S_RJ;
            end else if (!sel) begin
              sel   <= 1'b1;
              step  <= '0;
              j     <= '0;
              state <= S_RJ;
            end else begin
              k     <= '0;
              state <= S_OF;
            end
          end
        end
        S_OI: state <= S_OA;
        S_OA: state <= S_OB;
        S_OB: state <= S_OC;
        S_OC: state <= S_OD;
        S_OD: state <= S_OE;
        S_OE: state <= S_OF;
        S_OF: begin
          if (res_ready) begin
            if (last_k) begin
              state <= S_LOAD;
            end else begin
              k     <= K_W'(k + 1'b1);
              state <= S_OI;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_mul_done_in_wb: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_WB)
    else $error("multiply result arrived outside write-back");

  a_load_count_range: assert property (@(posedge clk) disable iff (rst)
    load_count <= CNT_W'(ORDER - 1))
    else $error("load count beyond frame length");

  a_last_returns_to_load: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.last) |=> in_ready)
    else $error("not ready for a new frame after the last coefficient");

  a_lead_not_reread: assert property (@(posedge clk) disable iff (rst)
    state == S_OI |-> k != '0)
    else $error("leading coefficient sent through the fold path");

endmodule

// ===== design/lsp_to_lpc_converter.sv =====
// Top level of the LSP to LPC converter: stream ports and the output register.
// Instantiates lsp2lpc_core (which holds lsp2lpc_mul). Uses lsp2lpc_pkg.
//
//  channel  | direction | tdata (low bit up)                     | tlast
//  s_axis   | in        | [15:0] lsp_value                       | -
//  m_axis   | out       | [15:0] coef_value, [19:16] coef_index  | coef_last
//
// Words 1 to ORDER-1 of a frame are stored as they arrive. The ORDER-th word starts
// the build: HALF*(HALF+1) coefficient updates, each stepping through S_RJ, S_RM,
// S_RN, S_ADD and S_WB, paced by the single shared multiplier and the one read
// port of the polynomial memory. Then the leading coefficient is sent, and each
// further one passes through S_OI to S_OF. s_axis_tready stays low meanwhile.
// A stalled m_axis holds the sequencer on the waiting word. Reset is synchronous.
module lsp_to_lpc_converter #(
  parameter int ORDER = lsp2lpc_pkg::LPC_ORDER
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lsp2lpc_pkg::LSP_W-1:0]       s_axis_tdata,   // [15:0] lsp_value
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lsp2lpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [15:0] coef_value, [19:16] coef_index
  output logic                                m_axis_tlast    // coef_last
);
  import lsp2lpc_pkg::*;

  logic       res_valid;
  logic       res_ready;
  coef_word_t res;

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  lsp2lpc_core #(
    .ORDER (ORDER)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_value  ($signed(s_axis_tdata)),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {{OUT_PAD_W{1'b0}}, res.index, res.value};
      m_axis_tlast <= res.last;
    end
  end

endmodule
